@@ rtl/sscsv_pkg.sv @@
package sscsv_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] COL_NAME   = 4'd0;
    localparam logic [3:0] COL_X      = 4'd1;
    localparam logic [3:0] COL_Y      = 4'd2;
    localparam logic [3:0] COL_W      = 4'd3;
    localparam logic [3:0] COL_H      = 4'd4;
    localparam logic [3:0] COL_PAD_L  = 4'd5;
    localparam logic [3:0] COL_PAD_T  = 4'd6;
    localparam logic [3:0] COL_PAD_W  = 4'd7;
    localparam logic [3:0] COL_PAD_H  = 4'd8;
    localparam logic [3:0] COL_LIMIT  = 4'd9;

    localparam int TDATA_BITS = 152;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_STOPPED
    } phase_t;

    typedef struct packed {
        logic [7:0]         name_length;
        logic signed [16:0] rect_left_half;
        logic signed [16:0] rect_top_half;
        logic signed [18:0] rect_right_half;
        logic signed [18:0] rect_bottom_half;
        logic signed [15:0] pad_left;
        logic signed [15:0] pad_top;
        logic signed [16:0] pad_right;
        logic signed [16:0] pad_bottom;
        logic [3:0]         column_count;
    } record_t;

endpackage

@@ rtl/sprite_sheet_csv_record_parser_core.sv @@
// Sprite-sheet CSV record parser.
// The slave stream carries one text byte per beat. The master stream carries one
// record per line terminator (carriage return or line feed), so a CR LF pair gives
// an extra empty record and an unterminated last line gives none.
// Every byte is parsed in the cycle it is accepted; a record goes to the output
// register, or to the skid register if it stalls. The block takes one byte per
// cycle, limited only by the two-entry output stage: an output register plus a
// skid register. While the receiver stalls, bytes keep flowing until one record
// waits in each of the two registers; then tready drops until the output drains.
// Reset clears the line state and empties both output registers, so the first byte
// after reset starts the name column of a new line.
module sprite_sheet_csv_record_parser_core import sscsv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_byte [7:0].
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // name_length, rect_left_half, rect_top_half, rect_right_half, rect_bottom_half,
    // pad_left, pad_top, pad_right, pad_bottom, column_count, then two zero bits.
    output logic [TDATA_BITS-1:0] m_axis_tdata
);

    logic    in_accept;
    logic    pop;
    logic    rec_emit;
    record_t rec;
    record_t out_data_reg,  out_data_next;
    record_t skid_data_reg, skid_data_next;
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;

    sscsv_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_accept (in_accept),
        .beat_data   (s_axis_tdata),
        .rec_emit    (rec_emit),
        .rec         (rec)
    );

    always_comb
    begin
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = rec;
                out_valid_next = rec_emit;
            end
        end
        else if (rec_emit)
        begin
            skid_data_next  = rec;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_data_reg.column_count,
                            out_data_reg.pad_bottom,
                            out_data_reg.pad_right,
                            out_data_reg.pad_top,
                            out_data_reg.pad_left,
                            out_data_reg.rect_bottom_half,
                            out_data_reg.rect_right_half,
                            out_data_reg.rect_top_half,
                            out_data_reg.rect_left_half,
                            out_data_reg.name_length};

    skid_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a record while the output register is empty");

    skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid register filled without a stalled output");

    term_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ((s_axis_tdata == CHAR_LF) || (s_axis_tdata == CHAR_CR)))
        |=> m_axis_tvalid)
        else $error("accepted line terminator produced no record");

    only_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
        rec_emit |-> (in_accept && ((s_axis_tdata == CHAR_LF) || (s_axis_tdata == CHAR_CR))))
        else $error("record emitted without an accepted line terminator");

endmodule

@@ rtl/sscsv_parser.sv @@
module sscsv_parser import sscsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_accept,
    input  logic [7:0] beat_data,
    output logic       rec_emit,
    output record_t    rec
);

    logic [3:0]         column_reg,      column_next;
    phase_t             phase_reg,       phase_next;
    logic               negative_reg,    negative_next;
    logic [15:0]        magnitude_reg,   magnitude_next;
    logic [7:0]         name_len_reg,    name_len_next;
    logic signed [16:0] left_reg,        left_next;
    logic signed [16:0] top_reg,         top_next;
    logic signed [18:0] right_reg,       right_next;
    logic signed [18:0] bottom_reg,      bottom_next;
    logic signed [15:0] pad_left_reg,    pad_left_next;
    logic signed [15:0] pad_top_reg,     pad_top_next;
    logic signed [16:0] pad_right_reg,   pad_right_next;
    logic signed [16:0] pad_bottom_reg,  pad_bottom_next;

    logic               is_term;
    logic               is_comma;
    logic               is_digit;
    logic               is_blank;
    logic [15:0]        neg_mag;
    logic signed [15:0] value;
    logic signed [16:0] value_x2;
    logic [19:0]        mag_times_ten;
    logic [15:0]        mag_accum;

    logic signed [16:0] left_c;
    logic signed [16:0] top_c;
    logic signed [18:0] right_c;
    logic signed [18:0] bottom_c;
    logic signed [15:0] pad_left_c;
    logic signed [15:0] pad_top_c;
    logic signed [16:0] pad_right_c;
    logic signed [16:0] pad_bottom_c;

    assign is_term  = (beat_data == CHAR_LF) || (beat_data == CHAR_CR);
    assign is_comma = (beat_data == CHAR_COMMA);
    assign is_digit = (beat_data >= CHAR_ZERO) && (beat_data <= CHAR_NINE);
    assign is_blank = (beat_data == CHAR_SPACE) || (beat_data == CHAR_TAB)
                   || (beat_data == CHAR_VT) || (beat_data == CHAR_FF);

    // Signed value of the column so far, clamped to 16 bits.
    assign neg_mag = 16'd0 - magnitude_reg;
    always_comb
    begin
        if (negative_reg)
        begin
            value = (magnitude_reg > 16'd32768) ? 16'sh8000 : $signed(neg_mag);
        end
        else
        begin
            value = (magnitude_reg > 16'd32767) ? 16'sh7FFF : $signed(magnitude_reg);
        end
    end
    assign value_x2 = $signed({value, 1'b0});

    // Decimal accumulate with saturation at the 16-bit maximum.
    assign mag_times_ten = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                         + {16'd0, 4'(beat_data - CHAR_ZERO)};
    assign mag_accum = (|mag_times_ten[19:16]) ? 16'hFFFF : mag_times_ten[15:0];

    // Column values after the pending number is committed.
    always_comb
    begin
        left_c       = left_reg;
        top_c        = top_reg;
        right_c      = right_reg;
        bottom_c     = bottom_reg;
        pad_left_c   = pad_left_reg;
        pad_top_c    = pad_top_reg;
        pad_right_c  = pad_right_reg;
        pad_bottom_c = pad_bottom_reg;
        unique case (column_reg)
            COL_X:     left_c       = $signed({value, 1'b1});
            COL_Y:     top_c        = $signed({value, 1'b1});
            COL_W:     right_c      = 19'(value_x2) + 19'(left_reg) - 19'sd2;
            COL_H:     bottom_c     = 19'(value_x2) + 19'(top_reg) - 19'sd2;
            COL_PAD_L: pad_left_c   = value;
            COL_PAD_T: pad_top_c    = value;
            COL_PAD_W: pad_right_c  = 17'(value) + 17'(pad_left_reg);
            COL_PAD_H: pad_bottom_c = 17'(value) + 17'(pad_top_reg);
            default:   ;
        endcase
    end

    always_comb
    begin
        column_next     = column_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        name_len_next   = name_len_reg;
        left_next       = left_reg;
        top_next        = top_reg;
        right_next      = right_reg;
        bottom_next     = bottom_reg;
        pad_left_next   = pad_left_reg;
        pad_top_next    = pad_top_reg;
        pad_right_next  = pad_right_reg;
        pad_bottom_next = pad_bottom_reg;

        rec_emit              = beat_accept && is_term;
        rec.name_length       = name_len_reg;
        rec.rect_left_half    = left_c;
        rec.rect_top_half     = top_c;
        rec.rect_right_half   = right_c;
        rec.rect_bottom_half  = bottom_c;
        rec.pad_left          = pad_left_c;
        rec.pad_top           = pad_top_c;
        rec.pad_right         = pad_right_c;
        rec.pad_bottom        = pad_bottom_c;
        rec.column_count      = column_reg + 4'd1;

        if (beat_accept)
        begin
            if (is_term)
            begin
                column_next     = COL_NAME;
                phase_next      = PH_SKIP;
                negative_next   = 1'b0;
                magnitude_next  = '0;
                name_len_next   = '0;
                left_next       = '0;
                top_next        = '0;
                right_next      = '0;
                bottom_next     = '0;
                pad_left_next   = '0;
                pad_top_next    = '0;
                pad_right_next  = '0;
                pad_bottom_next = '0;
            end
            else if (is_comma)
            begin
                left_next       = left_c;
                top_next        = top_c;
                right_next      = right_c;
                bottom_next     = bottom_c;
                pad_left_next   = pad_left_c;
                pad_top_next    = pad_top_c;
                pad_right_next  = pad_right_c;
                pad_bottom_next = pad_bottom_c;
                if (column_reg < COL_LIMIT)
                begin
                    column_next = column_reg + 4'd1;
                end
                phase_next     = PH_SKIP;
                negative_next  = 1'b0;
                magnitude_next = '0;
            end
            else if (column_reg == COL_NAME)
            begin
                if (name_len_reg != 8'hFF)
                begin
                    name_len_next = name_len_reg + 8'd1;
                end
            end
            else if (column_reg < COL_LIMIT)
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (beat_data == CHAR_MINUS)
                        begin
                            phase_next    = PH_DIGITS;
                            negative_next = 1'b1;
                        end
                        else if (beat_data == CHAR_PLUS)
                        begin
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            phase_next     = PH_DIGITS;
                            magnitude_next = mag_accum;
                        end
                        else if (!is_blank)
                        begin
                            phase_next = PH_STOPPED;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            magnitude_next = mag_accum;
                        end
                        else
                        begin
                            phase_next = PH_STOPPED;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= COL_NAME;
            phase_reg      <= PH_SKIP;
            negative_reg   <= 1'b0;
            magnitude_reg  <= '0;
            name_len_reg   <= '0;
            left_reg       <= '0;
            top_reg        <= '0;
            right_reg      <= '0;
            bottom_reg     <= '0;
            pad_left_reg   <= '0;
            pad_top_reg    <= '0;
            pad_right_reg  <= '0;
            pad_bottom_reg <= '0;
        end
        else
        begin
            column_reg     <= column_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
            name_len_reg   <= name_len_next;
            left_reg       <= left_next;
            top_reg        <= top_next;
            right_reg      <= right_next;
            bottom_reg     <= bottom_next;
            pad_left_reg   <= pad_left_next;
            pad_top_reg    <= pad_top_next;
            pad_right_reg  <= pad_right_next;
            pad_bottom_reg <= pad_bottom_next;
        end
    end

endmodule
